[rtl/ray_segment_hit_test_core_macros.svh]
// Assertion macros shared by the ray and segment hit test RTL.
`ifndef RAY_SEGMENT_HIT_TEST_CORE_MACROS_SVH
`define RAY_SEGMENT_HIT_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSHT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSHT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rsht_pkg.sv]
// Shared constants and types of the ray and segment hit test.
`default_nettype none

package rsht_pkg;

	// Limb width of the split wide multiplier and its register depth.
	localparam int MUL_LIMB = 32;
	localparam int MUL_LAT  = 4;

	// Status that leaves the divider next to the quotient.
	typedef struct packed {
		logic ovf;
		logic neg;
	} div_flags_t;

endpackage

`default_nettype wire

[rtl/rsht_mul.sv]
// Pipelined signed multiplier built from limb partial products.
`default_nettype none

module rsht_mul import rsht_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int NA  = (AW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int NB  = (BW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int AXW = NA * MUL_LIMB;
	localparam int BXW = NB * MUL_LIMB;
	localparam int RW  = (NB + 1) * MUL_LIMB;
	localparam int SW  = AXW + BXW;
	localparam int PW  = AW + BW;

	logic [AW-1:0]           abs_a;
	logic [BW-1:0]           abs_b;
	logic [AXW-1:0]          ma_s1;
	logic [BXW-1:0]          mb_s1;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [2*MUL_LIMB-1:0]   pp_s2 [NA][NB];
	logic [RW-1:0]           row_sum [NA];
	logic [RW-1:0]           row_s3 [NA];
	logic [SW-1:0]           total;
	logic signed [PW-1:0]    p_s4;

	// Magnitudes; the most negative value maps to its exact unsigned magnitude.
	always_comb begin
		abs_a = a[AW-1] ? AW'(~a) + AW'(1) : AW'(a);
		abs_b = b[BW-1] ? BW'(~b) + BW'(1) : BW'(b);
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_sum[i] = row_sum[i] + (RW'(pp_s2[i][j]) << (MUL_LIMB * j));
			end
		end
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < NA; i++) begin
			total = total + (SW'(row_s3[i]) << (MUL_LIMB * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= AXW'(abs_a);
			mb_s1  <= BXW'(abs_b);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*MUL_LIMB +: MUL_LIMB] * mb_s1[j*MUL_LIMB +: MUL_LIMB];
				end
			end
			for (int i = 0; i < NA; i++) begin
				row_s3[i] <= row_sum[i];
			end
			p_s4 <= neg_s3 ? -$signed(PW'(total)) : $signed(PW'(total));
		end
	end

	assign p = p_s4;

endmodule

`default_nettype wire

[rtl/rsht_div.sv]
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
`default_nettype none

module rsht_div import rsht_pkg::*; #(
	parameter int NW = 167,
	parameter int DW = 134,
	parameter int QB = 33
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic [QB:0]          quo,
	output div_flags_t           flags
);

	logic [NW-1:0]  mag;
	logic           ovf0;
	logic [NW-1:0]  rem_q [0:QB];
	logic [QB-1:0]  quo_q [0:QB];
	logic [DW-1:0]  den_q [0:QB];
	div_flags_t     flg_q [0:QB];
	logic           rnd;
	logic [QB:0]    quo_o;
	div_flags_t     flg_o;

	// A quotient of 2**QB or more is flagged and never resolved further.
	always_comb begin
		mag  = num[NW-1] ? NW'(~num) + NW'(1) : NW'(num);
		ovf0 = mag >= (NW'(den) << QB);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= mag;
			quo_q[0] <= '0;
			den_q[0] <= den;
			flg_q[0] <= '{ovf: ovf0, neg: num[NW-1]};
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		localparam int SH = QB - k;
		logic [NW-1:0] dsh;
		logic          ge;

		assign dsh = NW'(den_q[k-1]) << SH;
		assign ge  = rem_q[k-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_q[k-1] - dsh : rem_q[k-1];
				quo_q[k] <= quo_q[k-1] | (ge ? (QB'(1) << SH) : QB'(0));
				den_q[k] <= den_q[k-1];
				flg_q[k] <= flg_q[k-1];
			end
		end
	end

	// Round half away from zero on the magnitude.
	assign rnd = {rem_q[QB], 1'b0} >= (NW+1)'(den_q[QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_o <= (QB+1)'(quo_q[QB]) + (QB+1)'(rnd);
			flg_o <= flg_q[QB];
		end
	end

	assign quo   = quo_o;
	assign flags = flg_o;

endmodule

`default_nettype wire

[rtl/ray_segment_hit_test_core.sv]
// Top level of the ray and segment closest-approach hit test pipeline.
`default_nettype none
`include "ray_segment_hit_test_core_macros.svh"

// Channel  | Handshake                   | Payload
// query    | query_valid / query_stall   | ray_origin_*, ray_toward_*, segment_start_*, segment_end_*
// result   | result_valid / result_stall | hit, degenerate, point_x, point_y, point_z
//
// One word enters per cycle while the pipeline is not held; the quotient stages of the three
// dividers, one per coordinate, make up most of the pipeline depth.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The whole pipeline advances together; it holds in any cycle in which the result register
// is full and result_stall is high, and query_stall is raised in exactly those cycles.

module ray_segment_hit_test_core import rsht_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query_valid,
	output logic                          query_stall,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
	input  logic signed [COORD_WIDTH-1:0] ray_toward_x,
	input  logic signed [COORD_WIDTH-1:0] ray_toward_y,
	input  logic signed [COORD_WIDTH-1:0] ray_toward_z,
	input  logic signed [COORD_WIDTH-1:0] segment_start_x,
	input  logic signed [COORD_WIDTH-1:0] segment_start_y,
	input  logic signed [COORD_WIDTH-1:0] segment_start_z,
	input  logic signed [COORD_WIDTH-1:0] segment_end_x,
	input  logic signed [COORD_WIDTH-1:0] segment_end_y,
	input  logic signed [COORD_WIDTH-1:0] segment_end_z,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          hit,
	output logic                          degenerate,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z
);

	// Difference vectors need one extra bit, dot products two more beyond a full product,
	// and the second-level products (den, tn, sn) twice the dot width.
	localparam int W   = COORD_WIDTH;
	localparam int UW  = W + 1;
	localparam int DW  = 2 * UW + 2;
	localparam int PW  = 2 * DW;
	localparam int NW  = UW + PW;
	localparam int QB  = W + 1;
	localparam int SW  = W + 3;

	// Stage numbers: inputs and differences in stage 1, products in 2, dot products in 3.
	localparam int ST_DOT     = 3;
	localparam int ST_PQ      = ST_DOT + MUL_LAT;
	localparam int ST_NUM_IN  = ST_PQ + 1;
	localparam int ST_DIV_IN  = ST_NUM_IN + MUL_LAT;
	localparam int DIV_LAT    = QB + 2;
	localparam int ST_DIV_OUT = ST_DIV_IN + DIV_LAT;
	localparam int NST        = ST_DIV_OUT + 1;

	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	logic                   en;
	logic [NST:1]           vld_q;

	logic signed [W-1:0]    org_in [3];
	logic signed [W-1:0]    tow_in [3];
	logic signed [W-1:0]    sst_in [3];
	logic signed [W-1:0]    sen_in [3];

	// Origin travels to the divider output stage; ray direction u travels to the numerator multiply.
	logic signed [W-1:0]    org_q [1:ST_DIV_OUT][3];
	logic signed [UW-1:0]   ud_q  [1:ST_NUM_IN][3];
	logic signed [UW-1:0]   v_s1 [3];
	logic signed [UW-1:0]   w_s1 [3];

	logic signed [UW-1:0]   pa [15];
	logic signed [UW-1:0]   pb [15];
	logic signed [2*UW-1:0] prod_s2 [15];
	logic signed [DW-1:0]   dot_s3 [5];

	logic signed [DW-1:0]   ma [6];
	logic signed [DW-1:0]   mb [6];
	logic signed [PW-1:0]   pq [6];

	logic signed [PW-1:0]   den_s8, tn_s8, sn_s8;
	logic [1:0]             hf_q [ST_NUM_IN+1:ST_DIV_OUT];
	logic signed [PW-1:0]   dd_q [ST_NUM_IN+1:ST_DIV_IN];

	logic signed [NW-1:0]   num [3];
	logic [QB:0]            quo [3];
	div_flags_t             dfl [3];

	logic signed [SW-1:0]   off [3];
	logic signed [SW-1:0]   sum [3];
	logic signed [W-1:0]    pt  [3];

	logic                   hit_q, degenerate_q;
	logic signed [W-1:0]    point_q [3];

	assign result_valid = vld_q[NST];
	assign query_stall  = result_valid & result_stall;
	assign en           = ~query_stall;

	assign org_in = '{ray_origin_x, ray_origin_y, ray_origin_z};
	assign tow_in = '{ray_toward_x, ray_toward_y, ray_toward_z};
	assign sst_in = '{segment_start_x, segment_start_y, segment_start_z};
	assign sen_in = '{segment_end_x, segment_end_y, segment_end_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], query_valid};
		end
	end

	// Stage 1: u = T - O, v = E - S, w = O - S, all exact in one extra bit.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				org_q[1][k] <= org_in[k];
				ud_q[1][k]  <= UW'(tow_in[k]) - UW'(org_in[k]);
				v_s1[k]     <= UW'(sen_in[k]) - UW'(sst_in[k]);
				w_s1[k]     <= UW'(org_in[k]) - UW'(sst_in[k]);
			end
			for (int s = 2; s <= ST_DIV_OUT; s++) begin
				org_q[s] <= org_q[s-1];
			end
			for (int s = 2; s <= ST_NUM_IN; s++) begin
				ud_q[s] <= ud_q[s-1];
			end
		end
	end

	// Operand pairs of the five dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k]      = ud_q[1][k];
			pb[k]      = ud_q[1][k];
			pa[3 + k]  = ud_q[1][k];
			pb[3 + k]  = v_s1[k];
			pa[6 + k]  = v_s1[k];
			pb[6 + k]  = v_s1[k];
			pa[9 + k]  = ud_q[1][k];
			pb[9 + k]  = w_s1[k];
			pa[12 + k] = v_s1[k];
			pb[12 + k] = w_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 15; i++) begin
				prod_s2[i] <= pa[i] * pb[i];
			end
			for (int i = 0; i < 5; i++) begin
				dot_s3[i] <= DW'(prod_s2[3*i]) + DW'(prod_s2[3*i + 1]) + DW'(prod_s2[3*i + 2]);
			end
		end
	end

	// Second-level products: a*c, b*b, b*e, c*d, a*e, b*d.
	always_comb begin
		ma[0] = dot_s3[0]; mb[0] = dot_s3[2];
		ma[1] = dot_s3[1]; mb[1] = dot_s3[1];
		ma[2] = dot_s3[1]; mb[2] = dot_s3[4];
		ma[3] = dot_s3[2]; mb[3] = dot_s3[3];
		ma[4] = dot_s3[0]; mb[4] = dot_s3[4];
		ma[5] = dot_s3[1]; mb[5] = dot_s3[3];
	end

	for (genvar i = 0; i < 6; i++) begin : g_pq
		rsht_mul #(.AW(DW), .BW(DW)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (ma[i]),
			.b   (mb[i]),
			.p   (pq[i])
		);
	end

	// Denominator and the two parameter numerators, then the exact hit tests.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s8 <= pq[0] - pq[1];
			tn_s8  <= pq[2] - pq[3];
			sn_s8  <= pq[4] - pq[5];
			hf_q[ST_NUM_IN+1][1] <= den_s8 == '0;
			hf_q[ST_NUM_IN+1][0] <= (den_s8 != '0) && !tn_s8[PW-1] && !sn_s8[PW-1]
				&& (sn_s8 <= den_s8);
			for (int s = ST_NUM_IN + 2; s <= ST_DIV_OUT; s++) begin
				hf_q[s] <= hf_q[s-1];
			end
			dd_q[ST_NUM_IN+1] <= den_s8;
			for (int s = ST_NUM_IN + 2; s <= ST_DIV_IN; s++) begin
				dd_q[s] <= dd_q[s-1];
			end
		end
	end

	// Per coordinate: numerator u_k * tn, then round(num / den) in the divider.
	for (genvar k = 0; k < 3; k++) begin : g_axis
		rsht_mul #(.AW(UW), .BW(PW)) u_num (
			.clk (clk),
			.en  (en),
			.a   (ud_q[ST_NUM_IN][k]),
			.b   (tn_s8),
			.p   (num[k])
		);

		rsht_div #(.NW(NW), .DW(PW), .QB(QB)) u_div (
			.clk   (clk),
			.en    (en),
			.num   (num[k]),
			.den   (PW'(dd_q[ST_DIV_IN])),
			.quo   (quo[k]),
			.flags (dfl[k])
		);
	end

	// Offset the origin, saturate, and zero the point when there is no hit.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			off[k] = dfl[k].neg ? -$signed(SW'(quo[k])) : $signed(SW'(quo[k]));
			sum[k] = SW'(org_q[ST_DIV_OUT][k]) + off[k];
			if (dfl[k].ovf) begin
				pt[k] = dfl[k].neg ? CMIN : CMAX;
			end else if (sum[k] > SW'(CMAX)) begin
				pt[k] = CMAX;
			end else if (sum[k] < SW'(CMIN)) begin
				pt[k] = CMIN;
			end else begin
				pt[k] = W'(sum[k]);
			end
			if (!hf_q[ST_DIV_OUT][0]) begin
				pt[k] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q        <= hf_q[ST_DIV_OUT][0];
			degenerate_q <= hf_q[ST_DIV_OUT][1];
			point_q      <= pt;
		end
	end

	assign hit        = hit_q;
	assign degenerate = degenerate_q;
	assign point_x    = point_q[0];
	assign point_y    = point_q[1];
	assign point_z    = point_q[2];

	`RSHT_ASSERT_IMP(a_deg_no_hit, clk, arst_n, result_valid, !(hit && degenerate), "degenerate result reports a hit")
	`RSHT_ASSERT_IMP(a_miss_zero, clk, arst_n, result_valid && !hit, (point_x == '0) && (point_y == '0) && (point_z == '0), "miss carries a nonzero point")
	`RSHT_ASSERT_NXT(a_freeze, clk, arst_n, !en, vld_q == $past(vld_q), "pipeline moved while stalled")
	`RSHT_ASSERT_NXT(a_enter, clk, arst_n, query_valid && !query_stall, vld_q[1], "accepted word not in stage one")

endmodule

`default_nettype wire

[tb/sv/ray_segment_hit_test_core_test.sv]
// Self-checking testbench of the ray and segment closest-approach hit test core.
`timescale 1ns / 100ps

module ray_segment_hit_test_core_test;
	import rsht_pkg::*;

	localparam int CW = 32;
	// Idle cycles allowed with nothing accepted on either channel before giving up.
	localparam int STUCK_LIMIT = 4000;
	// Cycles of quiet that follow the last result; well above the pipeline depth.
	localparam int DRAIN_CYCLES = 2 * (CW + 16) + 20;

	// Exact products of the geometry need up to 169 bits; 256 leaves margin.
	typedef logic signed [255:0] exact_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t origin[3];
		coord_t toward[3];
		coord_t seg_a[3];
		coord_t seg_b[3];
	} query_t;

	typedef struct {
		logic   hit;
		logic   degenerate;
		coord_t point[3];
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic query_valid = 1'b0;
	logic query_stall;
	coord_t ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
	coord_t ray_toward_x = '0, ray_toward_y = '0, ray_toward_z = '0;
	coord_t segment_start_x = '0, segment_start_y = '0, segment_start_z = '0;
	coord_t segment_end_x = '0, segment_end_y = '0, segment_end_z = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic hit, degenerate;
	coord_t point_x, point_y, point_z;

	// Answers the core still owes, oldest first.
	answer_t owed_answers[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	ray_segment_hit_test_core #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.query_valid(query_valid), .query_stall(query_stall),
		.ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y), .ray_origin_z(ray_origin_z),
		.ray_toward_x(ray_toward_x), .ray_toward_y(ray_toward_y), .ray_toward_z(ray_toward_z),
		.segment_start_x(segment_start_x), .segment_start_y(segment_start_y),
		.segment_start_z(segment_start_z),
		.segment_end_x(segment_end_x), .segment_end_y(segment_end_y),
		.segment_end_z(segment_end_z),
		.result_valid(result_valid), .result_stall(result_stall),
		.hit(hit), .degenerate(degenerate),
		.point_x(point_x), .point_y(point_y), .point_z(point_z)
	);

	always #2 clk = ~clk;

	// Predicts one answer with exact integer arithmetic in raw coordinate units.
	// The lines are u = T - O and v = E - S, with w = O - S joining them; the
	// ray parameter is tn / den and the segment parameter is sn / den.
	function automatic answer_t closest_approach(query_t q);
		exact_t u[3], v[3], w[3];
		exact_t uu, uv, vv, uw, vw, den, tn, sn, num, mag, quo, rem, pos;
		exact_t lo, hi;
		answer_t ans;
		lo = -(exact_t'(1) <<< (CW - 1));
		hi = (exact_t'(1) <<< (CW - 1)) - 1;
		ans.hit = 1'b0;
		ans.degenerate = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ans.point[k] = '0;
			u[k] = exact_t'(q.toward[k]) - exact_t'(q.origin[k]);
			v[k] = exact_t'(q.seg_b[k]) - exact_t'(q.seg_a[k]);
			w[k] = exact_t'(q.origin[k]) - exact_t'(q.seg_a[k]);
		end
		uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
		uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
		vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
		uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
		vw = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
		den = uu*vv - uv*uv;
		tn = uv*vw - vv*uw;
		sn = uu*vw - uv*uw;
		if (den == 0) begin
			ans.degenerate = 1'b1;
			return ans;
		end
		if (tn < 0 || sn < 0 || sn > den)
			return ans;
		ans.hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			num = u[k] * tn;
			mag = (num < 0) ? -num : num;
			quo = mag / den;
			rem = mag % den;
			// Round to nearest, ties away from zero.
			if (2 * rem >= den)
				quo = quo + 1;
			if (quo >= (exact_t'(1) <<< 62)) begin
				pos = (num < 0) ? lo : hi;
			end else begin
				pos = exact_t'(q.origin[k]) + ((num < 0) ? -quo : quo);
				if (pos < lo) pos = lo;
				if (pos > hi) pos = hi;
			end
			ans.point[k] = pos[CW-1:0];
		end
		return ans;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Sends one word, with a random idle gap ahead of it, and records the answer
	// that the core owes once the word is accepted.
	task automatic send_query(input query_t q);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		ray_origin_x <= q.origin[0]; ray_origin_y <= q.origin[1]; ray_origin_z <= q.origin[2];
		ray_toward_x <= q.toward[0]; ray_toward_y <= q.toward[1]; ray_toward_z <= q.toward[2];
		segment_start_x <= q.seg_a[0]; segment_start_y <= q.seg_a[1];
		segment_start_z <= q.seg_a[2];
		segment_end_x <= q.seg_b[0]; segment_end_y <= q.seg_b[1]; segment_end_z <= q.seg_b[2];
		query_valid <= 1'b1;
		do @(posedge clk); while (query_stall);
		owed_answers = {owed_answers, closest_approach(q)};
	endtask

	// Drops the query valid and waits until every owed answer has come back.
	task automatic drain_answers();
		@(negedge clk);
		query_valid <= 1'b0;
		wait (owed_answers.size() == 0);
	endtask

	// Receiver side: random stall decided at each falling edge.
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// Result checker: compares each accepted word with the oldest owed answer.
	always @(posedge clk) begin
		answer_t exp;
		if (arst_n && result_valid && !result_stall) begin
			if (owed_answers.size() == 0) begin
				report_mismatch("result word with no query outstanding");
			end else begin
				exp = owed_answers.pop_front();
				if (hit !== exp.hit)
					report_mismatch($sformatf("hit %b, expected %b", hit, exp.hit));
				if (degenerate !== exp.degenerate)
					report_mismatch($sformatf("degenerate %b, expected %b",
						degenerate, exp.degenerate));
				if (point_x !== exp.point[0])
					report_mismatch($sformatf("point_x %0d, expected %0d", point_x, exp.point[0]));
				if (point_y !== exp.point[1])
					report_mismatch($sformatf("point_y %0d, expected %0d", point_y, exp.point[1]));
				if (point_z !== exp.point[2])
					report_mismatch($sformatf("point_z %0d, expected %0d", point_z, exp.point[2]));
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((query_valid && !query_stall) || (result_valid && !result_stall)
				|| !arst_n || (owed_answers.size() == 0 && !query_valid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STUCK_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// A coordinate with a mix of full range, small, extreme and scaled values.
	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: begin
				case ($urandom_range(4))
					0: return {1'b1, {(CW-1){1'b0}}};
					1: return {1'b0, {(CW-1){1'b1}}};
					2: return '0;
					3: return '1;
					default: return coord_t'(1);
				endcase
			end
			default: return coord_t'($signed($urandom) >>> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic query_t make_query(input coord_t o0, o1, o2, t0, t1, t2,
			s0, s1, s2, e0, e1, e2);
		query_t q;
		q.origin = '{o0, o1, o2};
		q.toward = '{t0, t1, t2};
		q.seg_a = '{s0, s1, s2};
		q.seg_b = '{e0, e1, e2};
		return q;
	endfunction

	// Hand-picked queries: clean hits, each kind of miss, the segment ends,
	// degenerate inputs and the coordinate extremes.
	task automatic test_directed();
		coord_t mx, mn;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		// Ray along x crosses a segment standing in y: a plain hit.
		send_query(make_query(0, 0, 0, 65536, 0, 0, 196608, -65536, 0, 196608, 65536, 0));
		// The same segment behind the ray origin: ray parameter negative.
		send_query(make_query(0, 0, 0, 65536, 0, 0, -196608, -65536, 0, -196608, 65536, 0));
		// Segment that stops short of the ray line: segment parameter above one.
		send_query(make_query(0, 0, 0, 65536, 0, 0, 131072, -196608, 0, 131072, -65536, 0));
		// Segment that starts past the ray line: segment parameter below zero.
		send_query(make_query(0, 0, 0, 65536, 0, 0, 131072, 65536, 0, 131072, 196608, 0));
		// Segment ends touching the ray line, at parameter zero and at one.
		send_query(make_query(0, 0, 0, 65536, 0, 0, 131072, 0, 0, 131072, 65536, 0));
		send_query(make_query(0, 0, 0, 65536, 0, 0, 131072, 65536, 0, 131072, 0, 0));
		// Closest point at the ray origin itself.
		send_query(make_query(0, 0, 0, 65536, 0, 0, 0, -5, 3, 0, 5, 3));
		// Skew lines that never meet: only the parameters decide.
		send_query(make_query(7, 9, 11, 1000, 9, 11, 400, -300, 500, 400, 300, 700));
		// Zero-length ray, zero-length segment, parallel and collinear lines.
		send_query(make_query(5, 5, 5, 5, 5, 5, 0, 0, 0, 100, 3, 7));
		send_query(make_query(0, 0, 0, 100, 3, 7, 9, 9, 9, 9, 9, 9));
		send_query(make_query(0, 0, 0, 10, 20, 30, 1, 0, 0, 31, 60, 90));
		send_query(make_query(0, 0, 0, 10, 20, 30, 20, 40, 60, 30, 60, 90));
		// Everything zero.
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Extremes of the coordinates.
		send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx));
		send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mn, 0, mn, mx, 0));
		send_query(make_query(mn, 0, mx, mx, 0, mn, 0, mn, 0, 0, mx, 0));
		send_query(make_query(mx, mn, 0, mx - 1, mn + 1, 1, mn, mx, mn, mx, mn, mx));
		send_query(make_query(-1, -1, -1, 1, 1, 1, mx, -1, mn, mn, 1, mx));
		// Near-parallel lines give very large ray parameters.
		send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, -1, mx, 1, 1));
		send_query(make_query(mn, 0, 0, mn + 1, 0, 0, mn, 1, -1, mx, -1, 1));
		drain_answers();
	endtask

	// Mostly queries built to hit: a point is picked on or near the segment, and the
	// ray aims at that point. The rest are degenerate cases and plain noise.
	task automatic test_random(input int count);
		query_t q;
		longint aim, span;
		int f;
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 3; k++) begin
				q.origin[k] = rand_coord();
				q.seg_a[k] = rand_coord();
				q.seg_b[k] = rand_coord();
				q.toward[k] = rand_coord();
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					f = $urandom_range(0, 256);
					for (int k = 0; k < 3; k++) begin
						span = longint'(q.seg_b[k]) - longint'(q.seg_a[k]);
						aim = longint'(q.seg_a[k]) + (span * f) / 256
							+ $signed($urandom_range(0, 8)) - 4;
						if ($urandom_range(1))
							q.toward[k] = coord_t'(aim);
						else
							q.toward[k] = coord_t'((longint'(q.origin[k]) + aim) / 2);
					end
				end
				6: q.toward = q.origin;
				7: begin
					for (int k = 0; k < 3; k++)
						q.seg_b[k] = coord_t'(longint'(q.seg_a[k])
							+ (longint'(q.toward[k]) - longint'(q.origin[k])) * 3);
				end
				default: ;
			endcase
			send_query(q);
		end
		drain_answers();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 0; stall_pct = 0;
		test_directed();

		// Phases of no idling, idling on each side, then both, then neither.
		send_idle_pct = 0;  stall_pct = 0;  test_random(400);
		send_idle_pct = 66; stall_pct = 0;  test_random(400);
		send_idle_pct = 0;  stall_pct = 66; test_random(400);
		send_idle_pct = 21; stall_pct = 21; test_random(400);
		send_idle_pct = 0;  stall_pct = 0;  test_random(300);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/rsht_pkg.sv
rtl/rsht_mul.sv
rtl/rsht_div.sv
rtl/ray_segment_hit_test_core.sv
tb/sv/ray_segment_hit_test_core_test.sv
